### src/mec_pkg.sv
// Shared types, constants and byte-sequence functions for the markup escape converter.
package mec_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MARKUP_EN   = 2'd0;
	localparam logic [1:0] CFG_TAG_OPEN    = 2'd1;
	localparam logic [1:0] CFG_TAG_CLOSE   = 2'd2;
	localparam logic [1:0] CFG_ENTITY_OPEN = 2'd3;

	// Configuration reset values.
	localparam logic       RST_MARKUP_EN   = 1'b1;
	localparam logic [7:0] RST_TAG_OPEN    = 8'd3;
	localparam logic [7:0] RST_TAG_CLOSE   = 8'd4;
	localparam logic [7:0] RST_ENTITY_OPEN = 8'd5;

	// Character codes.
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_L    = 8'h6C;
	localparam logic [7:0] CH_G    = 8'h67;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_P    = 8'h70;
	localparam logic [7:0] CH_Q    = 8'h71;
	localparam logic [7:0] CH_U    = 8'h75;
	localparam logic [7:0] CH_O    = 8'h6F;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [2:0] {
		RUN_BYTE = 3'd0,
		RUN_LT   = 3'd1,
		RUN_GT   = 3'd2,
		RUN_AMP  = 3'd3,
		RUN_QUOT = 3'd4
	} run_kind_t;

	// One input's worth of output bytes, described compactly.
	typedef struct packed {
		run_kind_t  kind;
		logic [7:0] value;
	} run_t;

	function automatic logic [2:0] run_len(run_kind_t kind);
		case (kind)
			RUN_LT:   return 3'd4;
			RUN_GT:   return 3'd4;
			RUN_AMP:  return 3'd5;
			RUN_QUOT: return 3'd6;
			default:  return 3'd1;
		endcase
	endfunction

	function automatic logic [7:0] run_char(run_t run, logic [2:0] idx);
		logic [7:0] ch;
		ch = CH_SEMI;
		case (run.kind)
			RUN_LT: begin
				case (idx)
					3'd0:    ch = CH_AMP;
					3'd1:    ch = CH_L;
					3'd2:    ch = CH_T;
					default: ch = CH_SEMI;
				endcase
			end
			RUN_GT: begin
				case (idx)
					3'd0:    ch = CH_AMP;
					3'd1:    ch = CH_G;
					3'd2:    ch = CH_T;
					default: ch = CH_SEMI;
				endcase
			end
			RUN_AMP: begin
				case (idx)
					3'd0:    ch = CH_AMP;
					3'd1:    ch = CH_A;
					3'd2:    ch = CH_M;
					3'd3:    ch = CH_P;
					default: ch = CH_SEMI;
				endcase
			end
			RUN_QUOT: begin
				case (idx)
					3'd0:    ch = CH_AMP;
					3'd1:    ch = CH_Q;
					3'd2:    ch = CH_U;
					3'd3:    ch = CH_O;
					3'd4:    ch = CH_T;
					default: ch = CH_SEMI;
				endcase
			end
			default: ch = run.value;
		endcase
		return ch;
	endfunction

endpackage

### src/mec_classify.sv
// Configuration registers, tag and entity flags, and the classification stage.
module mec_classify import mec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       run_valid,
	output run_t       run,
	input  logic       run_take
);

	logic       markup_en_q;
	logic [7:0] tag_open_q;
	logic [7:0] tag_close_q;
	logic [7:0] entity_open_q;
	logic       inside_tag_q;
	logic       inside_entity_q;
	logic       valid_s1;
	run_t       run_s1;

	logic       emit;
	run_t       run_d;
	logic       tag_d;
	logic       entity_d;
	logic [7:0] c;
	logic       accept;

	assign cfg_ready = 1'b1;
	assign c         = in_data.in_byte;
	assign in_ready  = !valid_s1 || run_take;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			markup_en_q   <= RST_MARKUP_EN;
			tag_open_q    <= RST_TAG_OPEN;
			tag_close_q   <= RST_TAG_CLOSE;
			entity_open_q <= RST_ENTITY_OPEN;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MARKUP_EN:   markup_en_q   <= cfg_data[0];
				CFG_TAG_OPEN:    tag_open_q    <= cfg_data;
				CFG_TAG_CLOSE:   tag_close_q   <= cfg_data;
				CFG_ENTITY_OPEN: entity_open_q <= cfg_data;
				default:         markup_en_q   <= markup_en_q;
			endcase
		end
	end

	always_comb begin
		emit       = 1'b0;
		run_d.kind = RUN_BYTE;
		run_d.value = c;
		tag_d      = inside_tag_q;
		entity_d   = inside_entity_q;
		if (inside_tag_q) begin
			emit = markup_en_q;
			if (c == tag_close_q) begin
				tag_d       = 1'b0;
				run_d.value = CH_GT;
			end
		end else if (inside_entity_q) begin
			emit = markup_en_q;
			if (c == CH_SEMI) begin
				entity_d = 1'b0;
			end
		end else if (c == tag_open_q) begin
			tag_d       = 1'b1;
			emit        = markup_en_q;
			run_d.value = CH_LT;
		end else if (c == tag_close_q) begin
			emit        = markup_en_q;
			run_d.value = CH_GT;
		end else if (c == entity_open_q) begin
			entity_d    = 1'b1;
			emit        = markup_en_q;
			run_d.value = CH_AMP;
		end else begin
			emit = 1'b1;
			if (markup_en_q) begin
				case (c)
					CH_LT:   run_d.kind = RUN_LT;
					CH_GT:   run_d.kind = RUN_GT;
					CH_AMP:  run_d.kind = RUN_AMP;
					CH_QUOT: run_d.kind = RUN_QUOT;
					default: run_d.kind = RUN_BYTE;
				endcase
			end
		end
		if (in_data.end_of_text) begin
			tag_d    = 1'b0;
			entity_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q    <= 1'b0;
			inside_entity_q <= 1'b0;
			valid_s1        <= 1'b0;
		end else if (accept) begin
			inside_tag_q    <= tag_d;
			inside_entity_q <= entity_d;
			// An input that produces no bytes leaves the stage empty.
			valid_s1        <= emit;
		end else if (run_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_s1 <= run_d;
		end
	end

	assign run_valid = valid_s1;
	assign run       = run_s1;

endmodule

### src/mec_emit.sv
// Output sequencer that plays one run out as a series of bytes.
module mec_emit import mec_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      run_valid,
	input  run_t      run,
	output logic      run_take,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic       valid_s2;
	run_t       run_s2;
	logic [2:0] idx_s2;
	logic       last;

	assign last     = idx_s2 == (run_len(run_s2.kind) - 3'd1);
	assign run_take = !valid_s2 || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 3'd0;
		end else if (run_take) begin
			valid_s2 <= run_valid;
			idx_s2   <= 3'd0;
		end else if (out_ready) begin
			idx_s2 <= idx_s2 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (run_take) begin
			run_s2 <= run;
		end
	end

	assign out_valid            = valid_s2;
	assign out_data.out_byte    = run_char(run_s2, idx_s2);
	assign out_data.last_of_run = last;

endmodule

### src/markup_escape_converter.sv
// An accepted input is registered in the classification stage and then in the output sequencer,
// which presents its bytes. Throughput: one input per cycle when each gives one byte and the
// output is not stalled; an escape run holds the output sequencer until its last byte is taken,
// with one input buffered ahead. Inputs that give no bytes leave no entry in either stage.
// Reset clears both flags and both stages and restores the default markup enable and marker codes.
module markup_escape_converter import mec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	logic run_valid;
	run_t run;
	logic run_take;

	mec_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.run_valid (run_valid),
		.run       (run),
		.run_take  (run_take)
	);

	mec_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (run_valid),
		.run       (run),
		.run_take  (run_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### src/mec_checker.sv
// Port-level checks for the markup escape converter and their binding.
module mec_checker import mec_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cfg_ready,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A stalled output transaction keeps its byte.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// A run that is not finished continues in the next cycle.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_of_run |=> out_valid)
		else $error("run broken before its last byte");

	// Inside an escape sequence an ampersand is followed by neither another ampersand nor a semicolon.
	a_escape_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_of_run && out_data.out_byte == CH_AMP
		|=> out_data.out_byte != CH_AMP && out_data.out_byte != CH_SEMI)
		else $error("malformed escape sequence");

	// With nothing pending at the output, the input side is ready to take a transaction.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind markup_escape_converter mec_checker u_mec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
